// ===== hw/rtl/ssms_pkg.sv =====
// ----------------------------------------------------------------------------
// Seven-segment scanner package
// Shared constants, glyph table and the decoded-digit record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssms_pkg;

	localparam int NUM_DIGITS = 8;
	localparam int POS_W      = $clog2(NUM_DIGITS);
	localparam int WORD_W     = 16;
	localparam int MODE_W     = 5;
	localparam int SEG_W      = 8;
	localparam int NIBBLE_W   = 4;

	localparam logic [MODE_W-1:0] MODE_NONE = 5'h00;
	localparam logic [MODE_W-1:0] MODE_BIN  = 5'h01;
	localparam logic [MODE_W-1:0] MODE_HEX  = 5'h02;
	localparam logic [MODE_W-1:0] MODE_DEC  = 5'h10;

	localparam logic [POS_W-1:0] HEX_LAST = 3'd3;
	localparam logic [POS_W-1:0] DEC_LAST = 3'd4;

	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_BUTTON = 1'b1;

	// Fixed-point reciprocals of 10^(p+1) with enough fraction bits that the
	// fraction of word / 10^(p+1) is exact to one decimal digit for 16-bit words.
	localparam int FRAC_BITS = 33;
	localparam int RECIP_W   = 30;
	localparam int PROD_W    = WORD_W + RECIP_W;
	localparam logic [63:0] DEC_SCALE = 64'd1 << FRAC_BITS;
	localparam logic [RECIP_W-1:0] DEC_RECIP_0 = RECIP_W'((DEC_SCALE + 64'd9) / 64'd10);
	localparam logic [RECIP_W-1:0] DEC_RECIP_1 = RECIP_W'((DEC_SCALE + 64'd99) / 64'd100);
	localparam logic [RECIP_W-1:0] DEC_RECIP_2 = RECIP_W'((DEC_SCALE + 64'd999) / 64'd1000);
	localparam logic [RECIP_W-1:0] DEC_RECIP_3 = RECIP_W'((DEC_SCALE + 64'd9999) / 64'd10000);
	localparam logic [RECIP_W-1:0] DEC_RECIP_4 =
		RECIP_W'((DEC_SCALE + 64'd99999) / 64'd100000);

	localparam logic [SEG_W-1:0] GLYPH [16] = '{
		8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8,
		8'h80, 8'h90, 8'h88, 8'h83, 8'hc6, 8'ha1, 8'h86, 8'h8e
	};

	typedef struct packed {
		logic             shown;
		logic [POS_W-1:0] next_pos;
		logic [SEG_W-1:0] anode;
		logic [SEG_W-1:0] segments;
	} ssms_digit_t;

	function automatic logic [RECIP_W-1:0] dec_recip(input logic [POS_W-1:0] pos);
		unique case (pos)
			3'd0:    return DEC_RECIP_0;
			3'd1:    return DEC_RECIP_1;
			3'd2:    return DEC_RECIP_2;
			3'd3:    return DEC_RECIP_3;
			3'd4:    return DEC_RECIP_4;
			default: return '0;
		endcase
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/seven_segment_multimode_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// Seven-segment multimode scanner
// A tick beat is registered in the input stage, its digit in the output register.
// One beat per cycle when not stalled; the decimal digit multiply sets the path.
// A full output register that is not taken stalls only ticks that show a digit.
// Reset clears the switch word, mode and scan position; nothing is shown
// until a button beat selects the binary, hex or decimal mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module seven_segment_multimode_scanner_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          opcode,
	input  wire logic [ssms_pkg::WORD_W-1:0]   switches,
	input  wire logic [ssms_pkg::MODE_W-1:0]   buttons,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [ssms_pkg::SEG_W-1:0]         digit_select,
	output logic [ssms_pkg::SEG_W-1:0]         segments
);

	logic                          valid_s1;
	logic                          opcode_s1;
	logic [ssms_pkg::WORD_W-1:0]   switches_s1;
	logic [ssms_pkg::MODE_W-1:0]   buttons_s1;

	logic [ssms_pkg::WORD_W-1:0]   word_q;
	logic [ssms_pkg::MODE_W-1:0]   mode_q;
	logic [ssms_pkg::POS_W-1:0]    pos_q;

	logic                          out_valid_q;
	logic [ssms_pkg::SEG_W-1:0]    digit_select_q;
	logic [ssms_pkg::SEG_W-1:0]    segments_q;

	ssms_pkg::ssms_digit_t         digit;
	logic                          is_tick;
	logic                          produce;
	logic                          out_free;
	logic                          advance;

	ssms_digit_decode u_decode (
		.switch_word   (word_q),
		.display_mode  (mode_q),
		.scan_position (pos_q),
		.digit         (digit)
	);

	assign is_tick  = valid_s1 && (opcode_s1 == ssms_pkg::OP_TICK);
	assign produce  = is_tick && digit.shown;
	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && (!produce || out_free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			opcode_s1   <= opcode;
			switches_s1 <= switches;
			buttons_s1  <= buttons;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
			mode_q <= ssms_pkg::MODE_NONE;
			pos_q  <= '0;
		end else if (advance) begin
			if (opcode_s1 == ssms_pkg::OP_BUTTON) begin
				word_q <= switches_s1;
				if (buttons_s1 != ssms_pkg::MODE_NONE) begin
					mode_q <= buttons_s1;
				end
			end else begin
				pos_q <= digit.next_pos;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && produce) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			digit_select_q <= digit.anode;
			segments_q     <= digit.segments;
		end
	end

	assign out_valid    = out_valid_q;
	assign digit_select = digit_select_q;
	assign segments     = segments_q;

	a_one_cold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ($countones(~digit_select_q) == 1))
		else $error("digit select is not one-cold");

	a_dp_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> segments_q[7])
		else $error("decimal point lit");

	a_mode_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != ssms_pkg::MODE_NONE) |=> (mode_q != ssms_pkg::MODE_NONE))
		else $error("display mode returned to none");

	a_hex_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(is_tick && advance && (mode_q == ssms_pkg::MODE_HEX)) |=>
		(pos_q <= ssms_pkg::HEX_LAST))
		else $error("hex scan position past its limit");

	a_dec_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(is_tick && advance && (mode_q == ssms_pkg::MODE_DEC)) |=>
		(pos_q <= ssms_pkg::DEC_LAST))
		else $error("decimal scan position past its limit");

endmodule

`default_nettype wire

// ===== hw/rtl/ssms_digit_decode.sv =====
// ----------------------------------------------------------------------------
// Seven-segment scanner digit decoder
// Picks the digit at the scan position in the current mode and encodes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssms_digit_decode (
	input  wire logic [ssms_pkg::WORD_W-1:0] switch_word,
	input  wire logic [ssms_pkg::MODE_W-1:0] display_mode,
	input  wire logic [ssms_pkg::POS_W-1:0]  scan_position,
	output ssms_pkg::ssms_digit_t            digit
);

	logic [ssms_pkg::PROD_W-1:0]      prod;
	logic [ssms_pkg::FRAC_BITS-1:0]   frac;
	logic [ssms_pkg::FRAC_BITS+3:0]   frac_x10;
	logic [ssms_pkg::NIBBLE_W-1:0]    dec_val;
	logic [ssms_pkg::NIBBLE_W-1:0]    hex_val;
	logic [ssms_pkg::NIBBLE_W-1:0]    val;
	logic [ssms_pkg::POS_W-1:0]       pos_inc;

	// The fraction of word / 10^(p+1), times ten, gives decimal digit p.
	assign prod     = ssms_pkg::PROD_W'(switch_word) *
	                  ssms_pkg::PROD_W'(ssms_pkg::dec_recip(scan_position));
	assign frac     = prod[ssms_pkg::FRAC_BITS-1:0];
	assign frac_x10 = {1'b0, frac, 3'b000} + {3'b000, frac, 1'b0};
	assign dec_val  = frac_x10[ssms_pkg::FRAC_BITS+3:ssms_pkg::FRAC_BITS];
	assign hex_val  = switch_word[{scan_position[1:0], 2'b00} +: ssms_pkg::NIBBLE_W];
	assign pos_inc  = scan_position + 3'd1;

	always_comb begin
		val            = '0;
		digit.shown    = 1'b1;
		digit.next_pos = pos_inc;
		case (display_mode)
			ssms_pkg::MODE_BIN: begin
				val = {3'b000, switch_word[{1'b0, scan_position}]};
			end
			ssms_pkg::MODE_HEX: begin
				val = (scan_position <= ssms_pkg::HEX_LAST) ? hex_val : '0;
				if (scan_position >= ssms_pkg::HEX_LAST) begin
					digit.next_pos = '0;
				end
			end
			ssms_pkg::MODE_DEC: begin
				val = (scan_position <= ssms_pkg::DEC_LAST) ? dec_val : '0;
				if (scan_position >= ssms_pkg::DEC_LAST) begin
					digit.next_pos = '0;
				end
			end
			default: begin
				digit.shown    = 1'b0;
				digit.next_pos = scan_position;
			end
		endcase
		digit.anode    = ~(8'b0000_0001 << scan_position);
		digit.segments = ssms_pkg::GLYPH[val];
	end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Seven-segment multimode scanner testbench
// Drives button events and display ticks through the valid/ready input and
// checks every digit beat against a cycle-free prediction of the scan. The
// run has a directed part, then random beats in four pacing phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_BEATS = 1600;

	localparam logic [7:0] SEG_GLYPH [16] = '{
		8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8,
		8'h80, 8'h90, 8'h88, 8'h83, 8'hc6, 8'ha1, 8'h86, 8'h8e
	};

	typedef struct {
		logic [7:0] anode;
		logic [7:0] pattern;
	} digit_t;

	class digit_scoreboard;
		logic [15:0] latched_word;
		logic [4:0]  mode;
		logic [2:0]  pos;
		digit_t      expected_digits[$];
		int          errors;

		function new();
			latched_word = '0;
			mode = ssms_pkg::MODE_NONE;
			pos = '0;
			errors = 0;
		endfunction

		function bit shows();
			return mode == ssms_pkg::MODE_BIN || mode == ssms_pkg::MODE_HEX ||
				mode == ssms_pkg::MODE_DEC;
		endfunction

		function int pending();
			return expected_digits.size();
		endfunction

		function void note_beat(logic op, logic [15:0] sw, logic [4:0] btn);
			int unsigned value;
			int unsigned limit;
			int unsigned quot;
			digit_t d;
			if (op == ssms_pkg::OP_BUTTON) begin
				latched_word = sw;
				if (btn != '0)
					mode = btn;
				return;
			end
			value = 0;
			case (mode)
				ssms_pkg::MODE_BIN: begin
					value = (latched_word >> pos) & 1;
					limit = 8;
				end
				ssms_pkg::MODE_HEX: begin
					if (pos < 4)
						value = (latched_word >> (4 * pos)) & 4'hf;
					limit = 4;
				end
				ssms_pkg::MODE_DEC: begin
					if (pos < 5) begin
						quot = latched_word;
						for (int i = 0; i < pos; i++)
							quot = quot / 10;
						value = quot % 10;
					end
					limit = 5;
				end
				default: return;
			endcase
			d.anode = ~(8'd1 << pos);
			d.pattern = SEG_GLYPH[value[3:0]];
			expected_digits.push_back(d);
			pos = (int'(pos) + 1 >= limit) ? 3'd0 : pos + 3'd1;
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_digit(logic [7:0] anode, logic [7:0] pattern);
			digit_t d;
			if (expected_digits.size() == 0) begin
				report($sformatf("unexpected digit beat %h/%h", anode, pattern));
				return;
			end
			d = expected_digits.pop_front();
			if (anode !== d.anode)
				report($sformatf("digit_select %h, expected %h", anode, d.anode));
			if (pattern !== d.pattern)
				report($sformatf("segments %h, expected %h", pattern, d.pattern));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        opcode = 1'b0;
	logic [15:0] switches = '0;
	logic [4:0]  buttons = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  digit_select;
	logic [7:0]  segments;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int cycle_count = 0;
	digit_scoreboard sb;

	seven_segment_multimode_scanner_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.switches(switches),
		.buttons(buttons),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.digit_select(digit_select),
		.segments(segments)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("seven_segment_multimode_scanner_unit test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
		if (arst_n && out_valid && out_ready)
			sb.check_digit(digit_select, segments);
	end

	task send_beat(logic op, logic [15:0] sw, logic [4:0] btn);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		switches <= sw;
		buttons <= btn;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_beat(op, sw, btn);
	endtask

	task directed_beats();
		send_beat(ssms_pkg::OP_TICK, 16'hffff, 5'h1f);
		send_beat(ssms_pkg::OP_BUTTON, 16'hffff, 5'h00);
		send_beat(ssms_pkg::OP_TICK, 16'h0000, 5'h00);
		send_beat(ssms_pkg::OP_BUTTON, 16'ha5c3, ssms_pkg::MODE_BIN);
		repeat (7)
			send_beat(ssms_pkg::OP_TICK, 16'h0000, 5'h00);
		// A switch to hex with the scan at position 7 lights that digit as zero.
		send_beat(ssms_pkg::OP_BUTTON, 16'hffff, ssms_pkg::MODE_HEX);
		repeat (5)
			send_beat(ssms_pkg::OP_TICK, 16'h5a5a, 5'h15);
		send_beat(ssms_pkg::OP_BUTTON, 16'hffff, ssms_pkg::MODE_DEC);
		repeat (5)
			send_beat(ssms_pkg::OP_TICK, 16'h0000, 5'h0a);
		send_beat(ssms_pkg::OP_BUTTON, 16'h0000, 5'h1f);
		send_beat(ssms_pkg::OP_TICK, 16'hffff, 5'h00);
	endtask

	task random_beats(int count, int idle_pct, int stall);
		int n;
		int r;
		logic op;
		logic [15:0] sw;
		logic [4:0] btn;
		send_idle_pct = idle_pct;
		stall_pct = stall;
		n = 0;
		while (n < count) begin
			sw = $urandom;
			btn = $urandom;
			case ($urandom_range(15))
				0: sw = '0;
				1: sw = '1;
				2: sw = 16'd9999;
				3: sw = 16'd10000;
				default: ;
			endcase
			op = ssms_pkg::OP_TICK;
			if ($urandom_range(99) < 20) begin
				op = ssms_pkg::OP_BUTTON;
				r = $urandom_range(99);
				if (r < 28)
					btn = ssms_pkg::MODE_BIN;
				else if (r < 56)
					btn = ssms_pkg::MODE_HEX;
				else if (r < 84)
					btn = ssms_pkg::MODE_DEC;
				else if (r < 92)
					btn = '0;
			end
			if (op == ssms_pkg::OP_BUTTON || sb.shows())
				n++;
			send_beat(op, sw, btn);
		end
	endtask

	initial begin
		sb = new();
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_beats();
		random_beats(RANDOM_BEATS / 4, 0, 0);
		random_beats(RANDOM_BEATS / 4, 76, 0);
		random_beats(RANDOM_BEATS / 4, 0, 76);
		random_beats(RANDOM_BEATS / 4, 15, 15);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20)
			@(posedge clk);
		if (sb.errors == 0)
			$display("seven_segment_multimode_scanner_unit test passed");
		else
			$display("seven_segment_multimode_scanner_unit test failed");
		$finish;
	end

endmodule
